// ===== rtl/interval_text_to_seconds_core_assert.svh =====
// Assertion macros used by the checker file of the interval parser.
`ifndef INTERVAL_TEXT_TO_SECONDS_CORE_ASSERT_SVH
`define INTERVAL_TEXT_TO_SECONDS_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define ITTS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ITTS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/itts_pkg.sv =====
// Types, constants and helpers shared by the interval parser modules.
`default_nettype none

package itts_pkg;

	localparam int VALUE_W     = 64;
	localparam int OUT_W       = 64;
	localparam int MAX_LETTERS = 7;
	localparam int LCNT_W      = $clog2(MAX_LETTERS + 2);
	localparam int LIDX_W      = $clog2(MAX_LETTERS);
	localparam int HALF_W      = VALUE_W / 2;
	localparam int UNIT_W      = 25;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);
	localparam int HMS_W       = 17;

	localparam logic [UNIT_W-1:0] SEC_DAY    = UNIT_W'(86400);
	localparam logic [UNIT_W-1:0] SEC_MONTH  = UNIT_W'(30 * 86400);
	localparam logic [UNIT_W-1:0] SEC_YEAR   = UNIT_W'(365 * 86400 + 86400 / 4);
	localparam logic [UNIT_W-1:0] SEC_HOUR   = UNIT_W'(3600);
	localparam logic [UNIT_W-1:0] SEC_MINUTE = UNIT_W'(60);
	localparam logic [UNIT_W-1:0] SEC_SECOND = UNIT_W'(1);

	// magnitude limits for positive and negative values
	localparam logic [VALUE_W-1:0] LIM_POS = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [VALUE_W-1:0] LIM_NEG = {1'b1, {(VALUE_W-1){1'b0}}};

	// mag*10+d stays in range iff mag < Q, or mag == Q and d <= R
	localparam logic [VALUE_W-1:0] DQ_POS = LIM_POS / 10;
	localparam logic [3:0]         DR_POS = 4'(LIM_POS % 10);
	localparam logic [VALUE_W-1:0] DQ_NEG = LIM_NEG / 10;
	localparam logic [3:0]         DR_NEG = 4'(LIM_NEG % 10);

	localparam logic [VALUE_W-1:0] LQ_POS_YEAR   = LIM_POS / SEC_YEAR;
	localparam logic [VALUE_W-1:0] LQ_POS_MONTH  = LIM_POS / SEC_MONTH;
	localparam logic [VALUE_W-1:0] LQ_POS_DAY    = LIM_POS / SEC_DAY;
	localparam logic [VALUE_W-1:0] LQ_POS_HOUR   = LIM_POS / SEC_HOUR;
	localparam logic [VALUE_W-1:0] LQ_POS_MINUTE = LIM_POS / SEC_MINUTE;
	localparam logic [VALUE_W-1:0] LQ_NEG_YEAR   = LIM_NEG / SEC_YEAR;
	localparam logic [VALUE_W-1:0] LQ_NEG_MONTH  = LIM_NEG / SEC_MONTH;
	localparam logic [VALUE_W-1:0] LQ_NEG_DAY    = LIM_NEG / SEC_DAY;
	localparam logic [VALUE_W-1:0] LQ_NEG_HOUR   = LIM_NEG / SEC_HOUR;
	localparam logic [VALUE_W-1:0] LQ_NEG_MINUTE = LIM_NEG / SEC_MINUTE;

	localparam logic [2:0] U_YEAR   = 3'd0;
	localparam logic [2:0] U_MONTH  = 3'd1;
	localparam logic [2:0] U_DAY    = 3'd2;
	localparam logic [2:0] U_HOUR   = 3'd3;
	localparam logic [2:0] U_MINUTE = 3'd4;
	localparam logic [2:0] U_SECOND = 3'd5;

	localparam logic [2:0] E_NONE     = 3'd0;
	localparam logic [2:0] E_NUMBER   = 3'd1;
	localparam logic [2:0] E_HOUR     = 3'd2;
	localparam logic [2:0] E_MINUTE   = 3'd3;
	localparam logic [2:0] E_SECOND   = 3'd4;
	localparam logic [2:0] E_GARBAGE  = 3'd5;
	localparam logic [2:0] E_OVERFLOW = 3'd6;

	localparam logic [2:0] CL_SPACE  = 3'd0;
	localparam logic [2:0] CL_DIGIT  = 3'd1;
	localparam logic [2:0] CL_SIGN   = 3'd2;
	localparam logic [2:0] CL_LETTER = 3'd3;
	localparam logic [2:0] CL_COLON  = 3'd4;
	localparam logic [2:0] CL_NUL    = 3'd5;
	localparam logic [2:0] CL_OTHER  = 3'd6;

	typedef struct packed {
		logic [7:0] ch;
		logic       is_end;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] total_seconds;
		logic [2:0]              error_code;
	} res_item_t;

	typedef struct packed {
		logic       is_end;
		logic [2:0] cls;
		logic [7:0] ch;
	} qitem_t;

	typedef struct packed {
		logic               is_last;
		logic [2:0]         err;
		logic               term;
		logic               neg;
		logic [2:0]         unit_sel;
		logic [VALUE_W-1:0] mag;
	} term_op_t;

	function automatic logic [UNIT_W-1:0] unit_secs(input logic [2:0] sel);
		logic [UNIT_W-1:0] s;
		unique case (sel)
			U_YEAR:   s = SEC_YEAR;
			U_MONTH:  s = SEC_MONTH;
			U_DAY:    s = SEC_DAY;
			U_HOUR:   s = SEC_HOUR;
			U_MINUTE: s = SEC_MINUTE;
			default:  s = SEC_SECOND;
		endcase
		return s;
	endfunction

	// largest magnitude that may be scaled by the unit without overflow
	function automatic logic [VALUE_W-1:0] unit_limit(input logic neg, input logic [2:0] sel);
		logic [VALUE_W-1:0] l;
		unique case (sel)
			U_YEAR:   l = neg ? LQ_NEG_YEAR   : LQ_POS_YEAR;
			U_MONTH:  l = neg ? LQ_NEG_MONTH  : LQ_POS_MONTH;
			U_DAY:    l = neg ? LQ_NEG_DAY    : LQ_POS_DAY;
			U_HOUR:   l = neg ? LQ_NEG_HOUR   : LQ_POS_HOUR;
			U_MINUTE: l = neg ? LQ_NEG_MINUTE : LQ_POS_MINUTE;
			default:  l = neg ? LIM_NEG       : LIM_POS;
		endcase
		return l;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/itts_front.sv =====
// Input side: takes text beats and tags each byte with its character class.
`default_nettype none

module itts_front (
	input  wire                 text_valid,
	output logic                text_ready,
	input  itts_pkg::in_item_t  text_data,
	input  wire                 q_full,
	output logic                q_push,
	output itts_pkg::qitem_t    q_item
);

	logic [7:0] c;

	assign c          = text_data.ch;
	assign text_ready = !q_full;
	assign q_push     = text_valid && !q_full;

	always_comb begin
		q_item.is_end = text_data.is_end;
		q_item.ch     = c;
		priority if (c == 8'h00)
			q_item.cls = itts_pkg::CL_NUL;
		else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))
			q_item.cls = itts_pkg::CL_SPACE;
		else if (c >= "0" && c <= "9")
			q_item.cls = itts_pkg::CL_DIGIT;
		else if (c == "+" || c == "-")
			q_item.cls = itts_pkg::CL_SIGN;
		else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
			q_item.cls = itts_pkg::CL_LETTER;
		else if (c == ":")
			q_item.cls = itts_pkg::CL_COLON;
		else
			q_item.cls = itts_pkg::CL_OTHER;
	end

endmodule

`default_nettype wire

// ===== rtl/itts_queue.sv =====
// Short FIFO of classified characters between the front end and the parser.
`default_nettype none

module itts_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  itts_pkg::qitem_t   push_item,
	output logic               full,
	input  wire                pop,
	output logic               not_empty,
	output itts_pkg::qitem_t   pop_item
);

	itts_pkg::qitem_t                mem_q [itts_pkg::QDEPTH];
	logic [itts_pkg::QPTR_W-1:0]     wr_q;
	logic [itts_pkg::QPTR_W-1:0]     rd_q;
	logic [itts_pkg::QCNT_W-1:0]     cnt_q;

	assign full      = (cnt_q == itts_pkg::QCNT_W'(itts_pkg::QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_item  = mem_q[rd_q];

	function automatic logic [itts_pkg::QPTR_W-1:0] ptr_inc(input logic [itts_pkg::QPTR_W-1:0] p);
		return (p == itts_pkg::QPTR_W'(itts_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= ptr_inc(wr_q);
			if (pop)
				rd_q <= ptr_inc(rd_q);
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/itts_parse.sv =====
// Parser stage: walks the text state machine and issues term and error ops.
`default_nettype none

module itts_parse (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wire                  item_valid,
	input  itts_pkg::qitem_t     item,
	output logic                 pop,
	output logic                 op_valid_s1,
	output itts_pkg::term_op_t   op_s1
);

	localparam logic [3:0] P_START      = 4'd0;
	localparam logic [3:0] P_LEADWS     = 4'd1;
	localparam logic [3:0] P_SIGN       = 4'd2;
	localparam logic [3:0] P_NUM        = 4'd3;
	localparam logic [3:0] P_AFTER_NUM  = 4'd4;
	localparam logic [3:0] P_UNIT       = 4'd5;
	localparam logic [3:0] P_AFTER_TERM = 4'd6;
	localparam logic [3:0] P_MIN        = 4'd7;
	localparam logic [3:0] P_SEC        = 4'd8;
	localparam logic [3:0] P_TRAIL      = 4'd9;
	localparam logic [3:0] P_DONE       = 4'd10;

	localparam int VW = itts_pkg::VALUE_W;
	localparam int LW = itts_pkg::LCNT_W;

	logic [3:0]        phase_q, phase_d;
	logic [VW-1:0]     mag_q, mag_d;
	logic              neg_q, neg_d;
	logic [1:0]        cnt_q, cnt_d;
	logic [LW-1:0]     lcnt_q, lcnt_d;
	logic [6:0]        min_q, min_d;
	logic [6:0]        sec_q, sec_d;
	logic              failed_q;
	logic [7:0]        letters_q [itts_pkg::MAX_LETTERS];

	logic                         let_we;
	logic [itts_pkg::LIDX_W-1:0]  let_idx;
	logic [55:0]                  word;
	logic [3:0]                   umatch;
	logic [3:0]                   dig;
	logic                         dig_ovf;
	logic [VW-1:0]                mag_next;
	logic [6:0]                   min_new;
	logic [6:0]                   sec_new;
	logic [itts_pkg::HMS_W-1:0]   hms;
	logic                         do_sos;
	logic                         do_end;
	logic [3:0]                   ws_ph;
	itts_pkg::term_op_t           op_c;

	// {hit, unit} for the buffered unit word
	function automatic logic [3:0] match_unit(input logic [55:0] w, input logic [LW-1:0] n);
		logic [3:0] r;
		r = '0;
		priority if (n == LW'(1)) begin
			priority if (w[55:48] == "y")      r = {1'b1, itts_pkg::U_YEAR};
			else if (w[55:48] == "d")          r = {1'b1, itts_pkg::U_DAY};
			else if (w[55:48] == "m")          r = {1'b1, itts_pkg::U_MINUTE};
			else if (w[55:48] == "s")          r = {1'b1, itts_pkg::U_SECOND};
		end else if (n == LW'(3)) begin
			priority if (w[55:32] == "mon")    r = {1'b1, itts_pkg::U_MONTH};
			else if (w[55:32] == "day")        r = {1'b1, itts_pkg::U_DAY};
			else if (w[55:32] == "min")        r = {1'b1, itts_pkg::U_MINUTE};
			else if (w[55:32] == "sec")        r = {1'b1, itts_pkg::U_SECOND};
		end else if (n == LW'(4)) begin
			priority if (w[55:24] == "year")   r = {1'b1, itts_pkg::U_YEAR};
			else if (w[55:24] == "mons")       r = {1'b1, itts_pkg::U_MONTH};
			else if (w[55:24] == "days")       r = {1'b1, itts_pkg::U_DAY};
			else if (w[55:24] == "hour")       r = {1'b1, itts_pkg::U_HOUR};
		end else if (n == LW'(5)) begin
			priority if (w[55:16] == "years")  r = {1'b1, itts_pkg::U_YEAR};
			else if (w[55:16] == "month")      r = {1'b1, itts_pkg::U_MONTH};
			else if (w[55:16] == "hours")      r = {1'b1, itts_pkg::U_HOUR};
		end else if (n == LW'(6)) begin
			priority if (w[55:8] == "months")  r = {1'b1, itts_pkg::U_MONTH};
			else if (w[55:8] == "minute")      r = {1'b1, itts_pkg::U_MINUTE};
			else if (w[55:8] == "second")      r = {1'b1, itts_pkg::U_SECOND};
		end else if (n == LW'(7)) begin
			priority if (w == "minutes")       r = {1'b1, itts_pkg::U_MINUTE};
			else if (w == "seconds")           r = {1'b1, itts_pkg::U_SECOND};
		end
		return r;
	endfunction

	assign pop = item_valid && en;

	always_comb begin
		for (int i = 0; i < 7; i++)
			word[55 - 8*i -: 8] = letters_q[i];
	end

	assign umatch   = match_unit(word, lcnt_q);
	assign dig      = item.ch[3:0];
	assign dig_ovf  = neg_q ?
		(mag_q > itts_pkg::DQ_NEG || (mag_q == itts_pkg::DQ_NEG && dig > itts_pkg::DR_NEG)) :
		(mag_q > itts_pkg::DQ_POS || (mag_q == itts_pkg::DQ_POS && dig > itts_pkg::DR_POS));
	assign mag_next = (mag_q << 3) + (mag_q << 1) + VW'(dig);
	assign min_new  = (min_q << 3) + (min_q << 1) + 7'(dig);
	assign sec_new  = (sec_q << 3) + (sec_q << 1) + 7'(dig);
	// hours are at most 24 by the time the seconds complete
	assign hms      = itts_pkg::HMS_W'(mag_q[4:0]) * itts_pkg::HMS_W'(3600)
	                + itts_pkg::HMS_W'(min_q) * itts_pkg::HMS_W'(60)
	                + itts_pkg::HMS_W'(sec_new);

	always_comb begin
		phase_d = phase_q;
		mag_d   = mag_q;
		neg_d   = neg_q;
		cnt_d   = cnt_q;
		lcnt_d  = lcnt_q;
		min_d   = min_q;
		sec_d   = sec_q;
		let_we  = 1'b0;
		let_idx = lcnt_q[itts_pkg::LIDX_W-1:0];
		do_sos  = 1'b0;
		do_end  = 1'b0;
		ws_ph   = P_LEADWS;
		op_c    = '0;

		if (item.is_end) begin
			op_c.is_last = 1'b1;
			do_end = (phase_q != P_DONE) && !failed_q;
		end else if (!failed_q && phase_q != P_DONE) begin
			if (item.cls == itts_pkg::CL_NUL) begin
				do_end = 1'b1;
			end else begin
				unique case (phase_q)
					P_START, P_LEADWS: begin
						do_sos = 1'b1;
						ws_ph  = P_LEADWS;
					end
					P_AFTER_TERM: begin
						do_sos = 1'b1;
						ws_ph  = P_AFTER_TERM;
					end
					P_SIGN: begin
						if (item.cls == itts_pkg::CL_DIGIT) begin
							mag_d   = VW'(dig);
							phase_d = P_NUM;
						end else begin
							op_c.err = itts_pkg::E_NUMBER;
						end
					end
					P_NUM, P_AFTER_NUM: begin
						priority if (phase_q == P_NUM && item.cls == itts_pkg::CL_DIGIT) begin
							if (dig_ovf)
								op_c.err = itts_pkg::E_OVERFLOW;
							else
								mag_d = mag_next;
						end else if (phase_q == P_NUM && item.cls == itts_pkg::CL_COLON) begin
							if (mag_q > VW'(24))
								op_c.err = itts_pkg::E_HOUR;
							min_d   = '0;
							cnt_d   = '0;
							phase_d = P_MIN;
						end else if (item.cls == itts_pkg::CL_LETTER) begin
							let_we  = 1'b1;
							let_idx = '0;
							lcnt_d  = LW'(1);
							phase_d = P_UNIT;
						end else begin
							do_sos = 1'b1;
							ws_ph  = P_AFTER_NUM;
						end
					end
					P_UNIT: begin
						if (item.cls == itts_pkg::CL_LETTER) begin
							let_we = (lcnt_q < LW'(itts_pkg::MAX_LETTERS));
							if (lcnt_q <= LW'(itts_pkg::MAX_LETTERS))
								lcnt_d = lcnt_q + 1'b1;
						end else if (umatch[3]) begin
							op_c.term     = 1'b1;
							op_c.neg      = neg_q;
							op_c.mag      = mag_q;
							op_c.unit_sel = umatch[2:0];
							phase_d       = P_AFTER_TERM;
							do_sos        = 1'b1;
							ws_ph         = P_AFTER_TERM;
						end else begin
							op_c.err = itts_pkg::E_NUMBER;
						end
					end
					P_MIN: begin
						priority if (cnt_q < 2'd2 && item.cls == itts_pkg::CL_DIGIT) begin
							min_d = min_new;
							cnt_d = cnt_q + 1'b1;
						end else if (cnt_q == 2'd2 && item.cls == itts_pkg::CL_COLON
						             && min_q < 7'd60) begin
							sec_d   = '0;
							cnt_d   = '0;
							phase_d = P_SEC;
						end else begin
							op_c.err = itts_pkg::E_MINUTE;
						end
					end
					P_SEC: begin
						if (cnt_q < 2'd2) begin
							if (item.cls != itts_pkg::CL_DIGIT) begin
								op_c.err = itts_pkg::E_SECOND;
							end else begin
								sec_d = sec_new;
								cnt_d = cnt_q + 1'b1;
								if (cnt_q == 2'd1) begin
									if (sec_new >= 7'd60) begin
										op_c.err = itts_pkg::E_SECOND;
									end else begin
										op_c.term     = 1'b1;
										op_c.neg      = neg_q;
										op_c.mag      = VW'(hms);
										op_c.unit_sel = itts_pkg::U_SECOND;
									end
								end
							end
						end else begin
							priority if (item.cls == itts_pkg::CL_DIGIT)
								op_c.err = itts_pkg::E_SECOND;
							else if (item.cls == itts_pkg::CL_SPACE)
								phase_d = P_TRAIL;
							else
								op_c.err = itts_pkg::E_GARBAGE;
						end
					end
					P_TRAIL: begin
						if (item.cls != itts_pkg::CL_SPACE)
							op_c.err = itts_pkg::E_GARBAGE;
					end
					default: ;
				endcase
			end
		end

		// start a number or skip whitespace
		if (do_sos) begin
			unique case (item.cls)
				itts_pkg::CL_SPACE: phase_d = ws_ph;
				itts_pkg::CL_SIGN: begin
					neg_d   = (item.ch == "-");
					mag_d   = '0;
					phase_d = P_SIGN;
				end
				itts_pkg::CL_DIGIT: begin
					neg_d   = 1'b0;
					mag_d   = VW'(dig);
					phase_d = P_NUM;
				end
				default: op_c.err = itts_pkg::E_NUMBER;
			endcase
		end

		// end of text, by end beat or by a zero byte
		if (do_end) begin
			unique case (phase_q)
				P_UNIT: begin
					if (umatch[3]) begin
						op_c.term     = 1'b1;
						op_c.neg      = neg_q;
						op_c.mag      = mag_q;
						op_c.unit_sel = umatch[2:0];
					end else begin
						op_c.err = itts_pkg::E_NUMBER;
					end
				end
				P_LEADWS, P_SIGN: op_c.err = itts_pkg::E_NUMBER;
				P_MIN:            op_c.err = itts_pkg::E_MINUTE;
				P_SEC: begin
					if (cnt_q < 2'd2)
						op_c.err = itts_pkg::E_SECOND;
				end
				default: ;
			endcase
			phase_d = P_DONE;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && let_we && !item.is_end)
			letters_q[let_idx] <= item.ch;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= P_START;
			mag_q    <= '0;
			neg_q    <= 1'b0;
			cnt_q    <= '0;
			lcnt_q   <= '0;
			min_q    <= '0;
			sec_q    <= '0;
			failed_q <= 1'b0;
		end else if (pop) begin
			if (item.is_end) begin
				phase_q  <= P_START;
				mag_q    <= '0;
				neg_q    <= 1'b0;
				cnt_q    <= '0;
				lcnt_q   <= '0;
				min_q    <= '0;
				sec_q    <= '0;
				failed_q <= 1'b0;
			end else begin
				phase_q  <= phase_d;
				mag_q    <= mag_d;
				neg_q    <= neg_d;
				cnt_q    <= cnt_d;
				lcnt_q   <= lcnt_d;
				min_q    <= min_d;
				sec_q    <= sec_d;
				failed_q <= failed_q || (op_c.err != itts_pkg::E_NONE);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			op_valid_s1 <= 1'b0;
		else if (en)
			op_valid_s1 <= pop;
	end

	always_ff @(posedge clk) begin
		if (pop)
			op_s1 <= op_c;
	end

endmodule

`default_nettype wire

// ===== rtl/itts_arith.sv =====
// Back end: scales terms by their unit, accumulates with overflow check, holds the result.
`default_nettype none

module itts_arith (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  op_valid_s1,
	input  itts_pkg::term_op_t   op_s1,
	output logic                 en,
	output logic                 result_valid,
	input  wire                  result_ready,
	output itts_pkg::res_item_t  result_data
);

	localparam int VW     = itts_pkg::VALUE_W;
	localparam int HW     = itts_pkg::HALF_W;
	localparam int UW     = itts_pkg::UNIT_W;
	localparam int PLO_W  = HW + UW;
	localparam int PHI_W  = VW - HW + UW;

	logic [UW-1:0]             usecs;

	logic                      valid_s2, last_s2, term_s2, neg_s2, rovf_s2;
	logic [2:0]                err_s2;
	logic [PLO_W-1:0]          plo_s2;
	logic [PHI_W-1:0]          phi_s2;

	logic                      valid_s3, last_s3, term_s3, neg_s3, rovf_s3;
	logic [2:0]                err_s3;
	logic [VW-1:0]             prod_s3;

	logic signed [VW-1:0]      total_q, total_n;
	logic [2:0]                err_q, err_n;
	logic [VW+1:0]             acc_a, acc_b, acc_sum;
	logic                      acc_ovf;

	assign en = !(result_valid && !result_ready && valid_s3 && last_s3);

	assign usecs = itts_pkg::unit_secs(op_s1.unit_sel);

	// multiply in two halves, combined in the next stage
	always_ff @(posedge clk) begin
		if (en) begin
			last_s2 <= op_s1.is_last;
			term_s2 <= op_s1.term;
			neg_s2  <= op_s1.neg;
			err_s2  <= op_s1.err;
			rovf_s2 <= op_s1.mag > itts_pkg::unit_limit(op_s1.neg, op_s1.unit_sel);
			plo_s2  <= PLO_W'(op_s1.mag[HW-1:0]) * PLO_W'(usecs);
			phi_s2  <= PHI_W'(op_s1.mag[VW-1:HW]) * PHI_W'(usecs);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s3 <= last_s2;
			term_s3 <= term_s2;
			neg_s3  <= neg_s2;
			err_s3  <= err_s2;
			rovf_s3 <= rovf_s2;
			prod_s3 <= VW'(plo_s2) + VW'({phi_s2, {HW{1'b0}}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s2 <= op_valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign acc_a   = {{2{total_q[VW-1]}}, total_q};
	assign acc_b   = {2'b00, prod_s3};
	assign acc_sum = neg_s3 ? acc_a - acc_b : acc_a + acc_b;
	assign acc_ovf = !(acc_sum[VW+1:VW-1] == 3'b000 || acc_sum[VW+1:VW-1] == 3'b111);

	// a term is applied before the error of the same beat; first error sticks
	always_comb begin
		total_n = total_q;
		err_n   = err_q;
		if (err_q == itts_pkg::E_NONE) begin
			if (term_s3) begin
				if (rovf_s3 || acc_ovf)
					err_n = itts_pkg::E_OVERFLOW;
				else
					total_n = acc_sum[VW-1:0];
			end
			if (err_n == itts_pkg::E_NONE)
				err_n = err_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q      <= '0;
			err_q        <= itts_pkg::E_NONE;
			result_valid <= 1'b0;
		end else begin
			if (en && valid_s3) begin
				if (last_s3) begin
					total_q <= '0;
					err_q   <= itts_pkg::E_NONE;
				end else begin
					total_q <= total_n;
					err_q   <= err_n;
				end
			end
			if (en && valid_s3 && last_s3)
				result_valid <= 1'b1;
			else if (result_ready)
				result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s3 && last_s3) begin
			result_data.total_seconds <= (err_n != itts_pkg::E_NONE) ? '0 :
				itts_pkg::OUT_W'(total_n);
			result_data.error_code    <= err_n;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/interval_text_to_seconds_core.sv =====
// An end beat passes through the queue, the parser op register, term stages s2 and s3 and the result register.
// Throughput: one text beat per cycle while nothing stalls; the classify queue, the parser stage and the
//   two-stage term multiplier each take one beat a cycle.
// The 4-entry queue keeps taking beats, until it is full, while a result waits in the output register.
// Reset (arst_n low, asynchronous): queue empty, parser before a number, total and error
//   cleared, no result pending.
`default_nettype none

module interval_text_to_seconds_core (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  text_valid,
	output logic                 text_ready,
	input  itts_pkg::in_item_t   text_data,
	output logic                 result_valid,
	input  wire                  result_ready,
	output itts_pkg::res_item_t  result_data
);

	logic                q_full;
	logic                q_push;
	itts_pkg::qitem_t    q_in;
	logic                q_pop;
	logic                q_not_empty;
	itts_pkg::qitem_t    q_out;
	logic                en;
	logic                op_valid_s1;
	itts_pkg::term_op_t  op_s1;

	itts_front u_front (
		.text_valid (text_valid),
		.text_ready (text_ready),
		.text_data  (text_data),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_item     (q_in)
	);

	itts_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_item  (q_out)
	);

	itts_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.item_valid  (q_not_empty),
		.item        (q_out),
		.pop         (q_pop),
		.op_valid_s1 (op_valid_s1),
		.op_s1       (op_s1)
	);

	itts_arith u_arith (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_valid_s1  (op_valid_s1),
		.op_s1        (op_s1),
		.en           (en),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

endmodule

`default_nettype wire

// ===== rtl/itts_checker.sv =====
// Port-level checks for the interval parser, bound to the top level.
`default_nettype none

`include "interval_text_to_seconds_core_assert.svh"

module itts_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  text_valid,
	input wire                  text_ready,
	input itts_pkg::in_item_t   text_data,
	input wire                  result_valid,
	input wire                  result_ready,
	input itts_pkg::res_item_t  result_data
);

	`ITTS_ASSERT_NXT(a_result_held, result_valid && !result_ready, result_valid && $stable(result_data), "result beat dropped or changed while stalled")
	`ITTS_ASSERT_IMP(a_error_zeroes_total, result_valid && result_data.error_code != itts_pkg::E_NONE, result_data.total_seconds == '0, "nonzero total reported with an error")
	`ITTS_ASSERT_IMP(a_error_code_known, result_valid, result_data.error_code <= itts_pkg::E_OVERFLOW, "unknown error code")

endmodule

bind interval_text_to_seconds_core itts_checker u_itts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.text_valid   (text_valid),
	.text_ready   (text_ready),
	.text_data    (text_data),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result_data  (result_data)
);

`default_nettype wire
